FILE: design/stil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types and constants of the integer-literal source tokenizer.
// ----------------------------------------------------------------------------
package stil_pkg;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_ZERO = 4'd1,
		PH_OCT  = 4'd2,
		PH_DEC  = 4'd3,
		PH_TAIL = 4'd4,
		PH_FRAC = 4'd5,
		PH_EXP0 = 4'd6,
		PH_EXPS = 4'd7,
		PH_EXPD = 4'd8,
		PH_NAME = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_BIN = 2'd2,
		RX_OCT = 2'd3
	} radix_t;

	localparam logic [2:0] TOK_END    = 3'd0;
	localparam logic [2:0] TOK_SINGLE = 3'd1;
	localparam logic [2:0] TOK_INT    = 3'd2;
	localparam logic [2:0] TOK_FLOAT  = 3'd3;
	localparam logic [2:0] TOK_NAME   = 3'd4;

	localparam int unsigned OUT_POS_W = 16;

	// Classified source byte handed from the front to the scanner.
	typedef struct packed {
		logic       eot;
		logic [7:0] code;
		logic       ws;
		logic       dig;
		logic       letus;
		logic       hexok;
		logic [3:0] hexv;
		logic       is_e;
		logic       is_x;
		logic       is_b;
		logic       dot;
		logic       sign;
		logic       zero;
	} item_t;

	typedef struct packed {
		logic bad;
		logic ovf;
	} flags_t;

	typedef struct packed {
		logic [2:0]           token_class;
		logic [7:0]           char_value;
		logic [63:0]          int_value;
		logic                 bad_digit;
		logic                 overflowed;
		logic                 exponent_missing;
		logic [OUT_POS_W-1:0] start_pos;
		logic [OUT_POS_W-1:0] end_pos;
		logic                 run_last;
	} res_t;

	// Handshake between the item queue and the scanner.
	typedef struct packed {
		logic  valid;
		item_t item;
	} item_port_t;

endpackage
`default_nettype wire

FILE: design/source_tokenizer_int_literal.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source tokenizer with integer literal conversion
// Path: a token caused by a byte is held in the item queue and then in the
// result queue before it is offered. Throughput: one byte per cycle while
// in_stall is low; tokens leave one per cycle while out_stall is low, so
// both tokens of a byte that closes one and forms another share the read port.
// Reset: arst_n clears the scanner state, position counter and both queues.
// ----------------------------------------------------------------------------
module source_tokenizer_int_literal #(
	parameter int unsigned POS_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       token_class,
	output logic [7:0]       char_value,
	output logic [63:0]      int_value,
	output logic             bad_digit,
	output logic             overflowed,
	output logic             exponent_missing,
	output logic [15:0]      start_pos,
	output logic [15:0]      end_pos,
	output logic             run_last
);

	stil_pkg::item_port_t item_head;
	logic                 item_pop;
	logic                 room;
	logic [1:0]           nres;
	stil_pkg::res_t       slot0;
	stil_pkg::res_t       slot1;
	stil_pkg::res_t       res_head;

	stil_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.head       (item_head),
		.pop        (item_pop)
	);

	stil_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (item_head),
		.pop   (item_pop),
		.room  (room),
		.nres  (nres),
		.slot0 (slot0),
		.slot1 (slot1)
	);

	stil_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.nwr      (nres),
		.w0       (slot0),
		.w1       (slot1),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (res_head)
	);

	assign token_class      = res_head.token_class;
	assign char_value       = res_head.char_value;
	assign int_value        = res_head.int_value;
	assign bad_digit        = res_head.bad_digit;
	assign overflowed       = res_head.overflowed;
	assign exponent_missing = res_head.exponent_missing;
	assign start_pos        = res_head.start_pos;
	assign end_pos          = res_head.end_pos;
	assign run_last         = res_head.run_last;

endmodule
`default_nettype wire

FILE: design/stil_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stil_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_code,
	input  wire logic               end_of_text,
	output stil_pkg::item_port_t    head,
	input  wire logic               pop
);

	stil_pkg::item_t q_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	stil_pkg::item_t cls;
	logic            push;

	always_comb begin
		cls       = '0;
		cls.eot   = end_of_text;
		cls.code  = char_code;
		cls.ws    = ((char_code >= 8'd9) && (char_code <= 8'd13)) || (char_code == 8'h20);
		cls.dig   = (char_code >= 8'h30) && (char_code <= 8'h39);
		cls.letus = ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
		            ((char_code >= 8'h41) && (char_code <= 8'h5a)) || (char_code == 8'h5f);
		cls.is_e  = (char_code == 8'h65) || (char_code == 8'h45);
		cls.is_x  = (char_code == 8'h78) || (char_code == 8'h58);
		cls.is_b  = (char_code == 8'h62) || (char_code == 8'h42);
		cls.dot   = (char_code == 8'h2e);
		cls.sign  = (char_code == 8'h2b) || (char_code == 8'h2d);
		cls.zero  = (char_code == 8'h30);
		if (cls.dig) begin
			cls.hexok = 1'b1;
			cls.hexv  = 4'(char_code - 8'h30);
		end else if ((char_code >= 8'h61) && (char_code <= 8'h66)) begin
			cls.hexok = 1'b1;
			cls.hexv  = 4'(char_code - 8'h57);
		end else if ((char_code >= 8'h41) && (char_code <= 8'h46)) begin
			cls.hexok = 1'b1;
			cls.hexv  = 4'(char_code - 8'h37);
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign head     = '{valid: (cnt_q != 2'd0), item: q_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("Item queue popped while empty.");

endmodule
`default_nettype wire

FILE: design/stil_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Runs the token state machine on one classified byte per cycle while the
// result queue has room, converts integer literals and makes up to two tokens per byte.
// ----------------------------------------------------------------------------
module stil_scan #(
	parameter int unsigned POS_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stil_pkg::item_port_t head,
	output logic                      pop,
	input  wire logic                 room,
	output logic [1:0]                nres,
	output stil_pkg::res_t            slot0,
	output stil_pkg::res_t            slot1
);

	localparam int unsigned OUT_W = stil_pkg::OUT_POS_W;

	stil_pkg::phase_t    phase_q, nxt_phase;
	logic [63:0]         acc_q, nxt_acc;
	stil_pkg::radix_t    radix_q, nxt_radix;
	stil_pkg::flags_t    flags_q, nxt_flags;
	logic [POS_BITS-1:0] start_q, nxt_start;
	logic [POS_BITS-1:0] pos_q, nxt_pos;

	stil_pkg::item_t     it;
	logic                ext;
	logic                do_acc;
	stil_pkg::radix_t    acc_rx;
	stil_pkg::phase_t    ext_phase;
	stil_pkg::radix_t    ext_radix;

	logic [3:0]          dig_v;
	logic                dig_bad;
	logic [3:0]          dig_use;
	logic [67:0]         scaled;
	logic [67:0]         sum;
	logic [63:0]         acc_new;
	stil_pkg::flags_t    flags_new;

	logic                have_flush;
	logic                have_second;
	stil_pkg::res_t      flush_res;
	stil_pkg::res_t      second_res;
	logic [POS_BITS-1:0] pos_inc;
	logic [OUT_W-1:0]    pos_now16;
	logic [OUT_W-1:0]    pos_inc16;
	logic [OUT_W-1:0]    start16;

	assign it      = head.item;
	assign pop     = head.valid && room;
	assign pos_inc = pos_q + POS_BITS'(1);

	// Positions leave the block as their low 16 bits.
	assign pos_now16 = OUT_W'({{OUT_W{1'b0}}, pos_q});
	assign pos_inc16 = OUT_W'({{OUT_W{1'b0}}, pos_inc});
	assign start16   = OUT_W'({{OUT_W{1'b0}}, start_q});

	always_comb begin
		ext       = 1'b0;
		do_acc    = 1'b0;
		acc_rx    = radix_q;
		ext_phase = phase_q;
		ext_radix = radix_q;
		unique case (phase_q)
			stil_pkg::PH_ZERO: begin
				priority if (it.is_x) begin
					ext = 1'b1; ext_radix = stil_pkg::RX_HEX; ext_phase = stil_pkg::PH_TAIL;
				end else if (it.is_b) begin
					ext = 1'b1; ext_radix = stil_pkg::RX_BIN; ext_phase = stil_pkg::PH_TAIL;
				end else if (it.dig) begin
					ext = 1'b1; ext_radix = stil_pkg::RX_OCT; ext_phase = stil_pkg::PH_OCT;
					do_acc = 1'b1; acc_rx = stil_pkg::RX_OCT;
				end else if (it.dot) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_FRAC;
				end else if (it.is_e) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXP0;
				end else if (it.hexok) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_TAIL; do_acc = 1'b1;
				end else begin
					ext = 1'b0;
				end
			end
			stil_pkg::PH_OCT, stil_pkg::PH_DEC: begin
				priority if (it.dig) begin
					ext = 1'b1; do_acc = 1'b1;
				end else if (it.dot) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_FRAC;
				end else if (it.is_e) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXP0;
				end else if (it.hexok) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_TAIL; do_acc = 1'b1;
				end else begin
					ext = 1'b0;
				end
			end
			stil_pkg::PH_TAIL: begin
				if (it.hexok) begin
					ext = 1'b1; do_acc = 1'b1;
				end
			end
			stil_pkg::PH_FRAC: begin
				priority if (it.dig) begin
					ext = 1'b1;
				end else if (it.is_e) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXP0;
				end else begin
					ext = 1'b0;
				end
			end
			stil_pkg::PH_EXP0: begin
				priority if (it.sign) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXPS;
				end else if (it.dig) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXPD;
				end else begin
					ext = 1'b0;
				end
			end
			stil_pkg::PH_EXPS, stil_pkg::PH_EXPD: begin
				if (it.dig) begin
					ext = 1'b1; ext_phase = stil_pkg::PH_EXPD;
				end
			end
			stil_pkg::PH_NAME: begin
				ext = it.letus || it.dig;
			end
			default: begin
				ext = 1'b0;
			end
		endcase
	end

	// One digit step of the literal conversion: acc * base + digit.
	always_comb begin
		dig_v = it.hexok ? it.hexv : 4'd0;
		unique case (acc_rx)
			stil_pkg::RX_HEX: dig_bad = 1'b0;
			stil_pkg::RX_BIN: dig_bad = (dig_v > 4'd1);
			stil_pkg::RX_OCT: dig_bad = (dig_v > 4'd7);
			default:          dig_bad = (dig_v > 4'd9);
		endcase
		dig_use = dig_bad ? 4'd0 : dig_v;
		unique case (acc_rx)
			stil_pkg::RX_HEX: scaled = {acc_q, 4'b0000};
			stil_pkg::RX_BIN: scaled = {3'b000, acc_q, 1'b0};
			stil_pkg::RX_OCT: scaled = {1'b0, acc_q, 3'b000};
			default:          scaled = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		endcase
		sum       = scaled + {64'd0, dig_use};
		acc_new   = acc_q;
		flags_new = flags_q;
		if (!flags_q.ovf) begin
			flags_new.bad = flags_q.bad || dig_bad;
			if (sum[67:64] != 4'd0) begin
				flags_new.ovf = 1'b1;
				acc_new       = 64'd0;
			end else begin
				acc_new = sum[63:0];
			end
		end
	end

	always_comb begin
		flush_res           = '0;
		flush_res.start_pos = start16;
		flush_res.end_pos   = pos_now16;
		unique case (phase_q)
			stil_pkg::PH_ZERO, stil_pkg::PH_OCT, stil_pkg::PH_DEC, stil_pkg::PH_TAIL: begin
				flush_res.token_class = stil_pkg::TOK_INT;
				flush_res.int_value   = flags_q.ovf ? 64'd0 : acc_q;
				flush_res.bad_digit   = flags_q.bad;
				flush_res.overflowed  = flags_q.ovf;
			end
			stil_pkg::PH_EXP0, stil_pkg::PH_EXPS: begin
				flush_res.token_class      = stil_pkg::TOK_FLOAT;
				flush_res.exponent_missing = 1'b1;
			end
			stil_pkg::PH_FRAC, stil_pkg::PH_EXPD: begin
				flush_res.token_class = stil_pkg::TOK_FLOAT;
			end
			default: begin
				flush_res.token_class = stil_pkg::TOK_NAME;
			end
		endcase
	end

	always_comb begin
		nxt_phase   = phase_q;
		nxt_acc     = acc_q;
		nxt_radix   = radix_q;
		nxt_flags   = flags_q;
		nxt_start   = start_q;
		nxt_pos     = pos_inc;
		have_flush  = 1'b0;
		have_second = 1'b0;
		second_res  = '0;
		if (it.eot) begin
			have_flush             = (phase_q != stil_pkg::PH_IDLE);
			have_second            = 1'b1;
			second_res.token_class = stil_pkg::TOK_END;
			second_res.start_pos   = pos_now16;
			second_res.end_pos     = pos_now16;
			nxt_phase              = stil_pkg::PH_IDLE;
			nxt_acc                = 64'd0;
			nxt_radix              = stil_pkg::RX_DEC;
			nxt_flags              = '0;
			nxt_start              = '0;
			nxt_pos                = '0;
		end else if (ext) begin
			nxt_phase = ext_phase;
			nxt_radix = ext_radix;
			if (do_acc) begin
				nxt_acc   = acc_new;
				nxt_flags = flags_new;
			end
		end else begin
			have_flush = (phase_q != stil_pkg::PH_IDLE);
			nxt_acc    = 64'd0;
			nxt_radix  = stil_pkg::RX_DEC;
			nxt_flags  = '0;
			nxt_start  = pos_q;
			priority if (it.ws) begin
				nxt_phase = stil_pkg::PH_IDLE;
			end else if (it.zero) begin
				nxt_phase = stil_pkg::PH_ZERO;
			end else if (it.dig) begin
				nxt_phase = stil_pkg::PH_DEC;
				nxt_acc   = {60'd0, it.hexv};
			end else if (it.dot) begin
				nxt_phase = stil_pkg::PH_FRAC;
			end else if (it.letus) begin
				nxt_phase = stil_pkg::PH_NAME;
			end else begin
				nxt_phase              = stil_pkg::PH_IDLE;
				have_second            = 1'b1;
				second_res.token_class = stil_pkg::TOK_SINGLE;
				second_res.char_value  = it.code;
				second_res.start_pos   = pos_now16;
				second_res.end_pos     = pos_inc16;
			end
		end
	end

	always_comb begin
		slot0          = have_flush ? flush_res : second_res;
		slot0.run_last = !(have_flush && have_second);
		slot1          = second_res;
		slot1.run_last = 1'b1;
		if (pop) begin
			nres = {1'b0, have_flush} + {1'b0, have_second};
		end else begin
			nres = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stil_pkg::PH_IDLE;
			acc_q   <= 64'd0;
			radix_q <= stil_pkg::RX_DEC;
			flags_q <= '0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (pop) begin
			phase_q <= nxt_phase;
			acc_q   <= nxt_acc;
			radix_q <= nxt_radix;
			flags_q <= nxt_flags;
			start_q <= nxt_start;
			pos_q   <= nxt_pos;
		end
	end

	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && it.eot) |=> (phase_q == stil_pkg::PH_IDLE) && (pos_q == '0))
		else $error("End of text did not return the scanner to its reset state.");

	a_eot_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && it.eot) |-> (nres != 2'd0))
		else $error("End of text produced no end token.");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.ovf |-> (acc_q == 64'd0))
		else $error("Accumulator holds a value after overflow.");

endmodule
`default_nettype wire

FILE: design/stil_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Four-entry token queue that takes up to two tokens per cycle and
// delivers one per transaction.
// ----------------------------------------------------------------------------
module stil_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     nwr,
	input  wire stil_pkg::res_t w0,
	input  wire stil_pkg::res_t w1,
	output logic                room,
	output logic                out_valid,
	input  wire logic           out_stall,
	output stil_pkg::res_t      head
);

	stil_pkg::res_t mem_q [4];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     cnt_q;
	logic           rd;

	assign room      = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign head      = mem_q[rd_ptr_q];
	assign rd        = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (nwr != 2'd0) begin
			mem_q[wr_ptr_q] <= w0;
		end
		if (nwr == 2'd2) begin
			mem_q[2'(wr_ptr_q + 2'd1)] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= 2'(wr_ptr_q + nwr);
			rd_ptr_q <= 2'(rd_ptr_q + {1'b0, rd});
			cnt_q    <= 3'(cnt_q + {1'b0, nwr} - {2'b00, rd});
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(nwr != 2'd0) |-> room)
		else $error("Result queue written without room.");

endmodule
`default_nettype wire
